FILE: rtl/hte_pkg.sv
// Package for the handle table engine: sizes, codes, slot record and helper functions.
`default_nettype none

package hte_pkg;

    localparam int SLOTS      = 4096;
    localparam int IDX_W      = (SLOTS > 2) ? $clog2(SLOTS) : 1;
    localparam int ROW_W      = 64;
    localparam int BIT_W      = $clog2(ROW_W);
    localparam int ROWS       = (SLOTS + ROW_W - 1) / ROW_W;
    localparam int ROW_AW     = (ROWS > 1) ? $clog2(ROWS) : 1;

    localparam int S_TDATA_W  = 144;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 56;

    localparam logic [31:0] FULL_ACCESS_BIT = 32'h1000_0000;

    localparam logic [1:0] KIND_CREATE = 2'd0;
    localparam logic [1:0] KIND_REF    = 2'd1;
    localparam logic [1:0] KIND_CLOSE  = 2'd2;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BAD_PARAM  = 3'd1;
    localparam logic [2:0] ST_FULL       = 3'd2;
    localparam logic [2:0] ST_BAD_HANDLE = 3'd3;
    localparam logic [2:0] ST_TYPE       = 3'd4;
    localparam logic [2:0] ST_DENIED     = 3'd5;

    typedef struct packed {
        logic [31:0] object_id;
        logic [7:0]  object_type;
        logic [31:0] access;
    } slot_t;

    // bits of a bitmap row that lie past the last slot read as taken
    function automatic logic [ROW_W-1:0] pad_mask(input logic [ROW_AW-1:0] row);
        logic [ROW_W-1:0] m;
        m = '0;
        for (int b = 0; b < ROW_W; b++) begin
            m[b] = ((int'(row) * ROW_W + b) >= SLOTS);
        end
        return m;
    endfunction

    function automatic logic [BIT_W-1:0] lowest_zero(input logic [ROW_W-1:0] w);
        logic [BIT_W-1:0] r;
        r = '0;
        for (int b = ROW_W - 1; b >= 0; b--) begin
            if (!w[b]) begin
                r = BIT_W'(b);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/handle_table_engine_top.sv
// Handle table engine: bitmap and slot memories with a read-modify-write sequencer.
//
//  channel | dir | fields
//  s_      | in  | tuser: kind; tdata: handle_in, object_id, object_type, grant_mask,
//          |     |        desired_mask, expected_type
//  m_      | out | tdata: status, handle_out, object_out
//
// For each beat, the accept cycle reads the bitmap row and slot record, and the
// execute state then checks, writes back and loads the output register.
// A create picks the lowest non-full row from a row-full flag vector, then the
// lowest clear bit in that row. Row-init flags make unwritten rows read as free,
// so reset needs no clearing pass. Reset is synchronous, active low.
// A stalled result holds the sequencer in its execute state; the next beat may be
// accepted while a result waits.
`default_nettype none

module handle_table_engine_top (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // [1:0] kind
    input  wire logic [hte_pkg::S_TUSER_W-1:0] s_tuser,
    // [31:0] handle_in, [63:32] object_id, [71:64] object_type,
    // [103:72] grant_mask, [135:104] desired_mask, [143:136] expected_type
    input  wire logic [hte_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [2:0] status, [17:3] handle_out, [49:18] object_out, [55:50] zero
    output logic [hte_pkg::M_TDATA_W-1:0]      m_tdata
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic state_reg, state_next;

    logic [hte_pkg::ROW_W-1:0]  bm_mem [hte_pkg::ROWS];
    hte_pkg::slot_t             dm_mem [hte_pkg::SLOTS];
    logic [hte_pkg::ROW_W-1:0]  bm_q_reg;
    hte_pkg::slot_t             dm_q_reg;

    logic [hte_pkg::ROWS-1:0]   init_reg;
    logic [hte_pkg::ROWS-1:0]   full_reg;

    logic [1:0]                 kind_reg;
    logic [31:0]                obj_reg;
    logic [7:0]                 otype_reg;
    logic [31:0]                grant_reg;
    logic [31:0]                desired_reg;
    logic [7:0]                 etype_reg;
    logic                       hok_reg;
    logic                       avail_reg;
    logic [hte_pkg::ROW_AW-1:0] row_reg;
    logic [hte_pkg::BIT_W-1:0]  bit_reg;

    logic                       m_valid_reg;
    logic [hte_pkg::M_TDATA_W-1:0] m_data_reg;

    logic        s_fire;
    logic        out_free;
    logic [31:0] in_handle;
    logic [29:0] hq;
    logic [29:0] hidx;
    logic        in_hok;
    logic [31:0] in_idx32;
    logic [hte_pkg::ROW_AW-1:0] free_row;
    logic        in_avail;
    logic [hte_pkg::ROW_AW-1:0] rd_row;
    logic [hte_pkg::IDX_W-1:0]  rd_idx;

    logic [hte_pkg::ROW_W-1:0]  word;
    logic [hte_pkg::ROW_W-1:0]  wordp;
    logic [hte_pkg::BIT_W-1:0]  free_bit;
    logic [31:0]                new_idx32;
    logic                       hit;
    logic [31:0]                gmask;

    logic                       bm_we;
    logic [hte_pkg::ROW_W-1:0]  bm_wdata;
    logic                       dm_we;
    logic [hte_pkg::IDX_W-1:0]  dm_waddr;
    logic [2:0]                 r_status;
    logic [14:0]                r_handle;
    logic [31:0]                r_object;
    logic                       set_full;
    logic                       clr_full;

    assign s_tready = (state_reg == S_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // handle decode at accept
    assign in_handle = s_tdata[31:0];
    assign hq        = in_handle[31:2];
    assign hidx      = hq - 30'd1;
    assign in_hok    = (in_handle != 32'd0) && (in_handle[1:0] == 2'b00)
                    && (32'(hidx) < 32'(hte_pkg::SLOTS));
    assign in_idx32  = 32'(hidx);

    always_comb begin
        free_row = '0;
        for (int r = hte_pkg::ROWS - 1; r >= 0; r--) begin
            if (!full_reg[r]) begin
                free_row = hte_pkg::ROW_AW'(r);
            end
        end
    end
    assign in_avail = !(&full_reg);

    always_comb begin
        if (s_tuser == hte_pkg::KIND_CREATE) begin
            rd_row = free_row;
        end else begin
            rd_row = hte_pkg::ROW_AW'(in_idx32 >> hte_pkg::BIT_W);
        end
    end
    assign rd_idx = hte_pkg::IDX_W'(in_idx32);

    // execute state
    assign word      = init_reg[row_reg] ? bm_q_reg : '0;
    assign wordp     = word | hte_pkg::pad_mask(row_reg);
    assign free_bit  = hte_pkg::lowest_zero(wordp);
    assign new_idx32 = (32'(row_reg) << hte_pkg::BIT_W) | 32'(free_bit);
    assign hit       = hok_reg && word[bit_reg];
    assign gmask     = ((dm_q_reg.access & hte_pkg::FULL_ACCESS_BIT) != 32'd0)
                     ? 32'hFFFF_FFFF : dm_q_reg.access;

    always_comb begin
        r_status = hte_pkg::ST_BAD_PARAM;
        r_handle = '0;
        r_object = '0;
        bm_we    = 1'b0;
        bm_wdata = word;
        dm_we    = 1'b0;
        dm_waddr = hte_pkg::IDX_W'(new_idx32);
        set_full = 1'b0;
        clr_full = 1'b0;
        unique case (kind_reg)
            hte_pkg::KIND_CREATE: begin
                if (obj_reg == 32'd0) begin
                    r_status = hte_pkg::ST_BAD_PARAM;
                end else if (!avail_reg || (&wordp)) begin
                    r_status = hte_pkg::ST_FULL;
                end else begin
                    r_status = hte_pkg::ST_OK;
                    r_handle = 15'((new_idx32 + 32'd1) << 2);
                    bm_we    = 1'b1;
                    bm_wdata = word | (hte_pkg::ROW_W'(1) << free_bit);
                    dm_we    = 1'b1;
                    set_full = &(wordp | (hte_pkg::ROW_W'(1) << free_bit));
                end
            end
            hte_pkg::KIND_REF: begin
                if (!hit) begin
                    r_status = hte_pkg::ST_BAD_HANDLE;
                end else if (etype_reg != 8'd0 && dm_q_reg.object_type != etype_reg) begin
                    r_status = hte_pkg::ST_TYPE;
                end else if (desired_reg != 32'd0 && (gmask & desired_reg) != desired_reg) begin
                    r_status = hte_pkg::ST_DENIED;
                end else begin
                    r_status = hte_pkg::ST_OK;
                    r_object = dm_q_reg.object_id;
                end
            end
            hte_pkg::KIND_CLOSE: begin
                if (!hit) begin
                    r_status = hte_pkg::ST_BAD_HANDLE;
                end else begin
                    r_status = hte_pkg::ST_OK;
                    bm_we    = 1'b1;
                    bm_wdata = word & ~(hte_pkg::ROW_W'(1) << bit_reg);
                    clr_full = 1'b1;
                end
            end
            default: begin
                r_status = hte_pkg::ST_BAD_PARAM;
            end
        endcase
    end

    logic commit;
    assign commit = (state_reg == S_EXEC) && out_free;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (s_fire) begin
                state_next = S_EXEC;
            end
            S_EXEC: if (out_free) begin
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            init_reg    <= '0;
            full_reg    <= '0;
        end else begin
            state_reg <= state_next;
            if (commit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            if (commit && bm_we) begin
                init_reg[row_reg] <= 1'b1;
            end
            if (commit && set_full) begin
                full_reg[row_reg] <= 1'b1;
            end else if (commit && clr_full) begin
                full_reg[row_reg] <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            kind_reg    <= s_tuser;
            obj_reg     <= s_tdata[63:32];
            otype_reg   <= s_tdata[71:64];
            grant_reg   <= s_tdata[103:72];
            desired_reg <= s_tdata[135:104];
            etype_reg   <= s_tdata[143:136];
            hok_reg     <= in_hok;
            avail_reg   <= in_avail;
            row_reg     <= rd_row;
            bit_reg     <= in_idx32[hte_pkg::BIT_W-1:0];
        end
        if (commit) begin
            m_data_reg <= {6'd0, r_object, r_handle, r_status};
        end
    end

    // bitmap memory
    always_ff @(posedge aclk) begin
        if (commit && bm_we) begin
            bm_mem[row_reg] <= bm_wdata;
        end
        if (s_fire) begin
            bm_q_reg <= bm_mem[rd_row];
        end
    end

    // slot record memory
    always_ff @(posedge aclk) begin
        if (commit && dm_we) begin
            dm_mem[dm_waddr] <= '{object_id: obj_reg, object_type: otype_reg,
                                  access: grant_reg};
        end
        if (s_fire) begin
            dm_q_reg <= dm_mem[rd_idx];
        end
    end

`ifndef SYNTHESIS
    a_accept_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> (state_reg == S_EXEC))
        else $error("accepted beat did not enter execute");

    a_full_init: assert property (@(posedge aclk) disable iff (!aresetn)
        (full_reg & ~init_reg) == '0)
        else $error("row marked full but never written");

    a_write_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        (bm_we || dm_we) && (state_reg == S_IDLE) |-> !commit)
        else $error("memory write outside execute");

    a_zero_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        commit && (r_status != hte_pkg::ST_OK) |-> (r_handle == 15'd0) && (r_object == 32'd0))
        else $error("result fields set on failure");

    a_dm_needs_bm: assert property (@(posedge aclk) disable iff (!aresetn)
        commit && dm_we |-> bm_we)
        else $error("slot written without bitmap update");
`endif

endmodule

`default_nettype wire
